FILE: hw/rtl/differential_drive_odometry_core_defines.svh
// Assertion macros for the odometry core checker.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_CORE_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_CORE_DEFINES_SVH

// property checked outside of reset
`define DDO_CHECK(lbl, prop) lbl: assert property (@(posedge clock) disable iff (reset) prop) \
   else $error("ddo check failed");

// property that also covers the reset cycles
`define DDO_CHECK_RST(lbl, prop) lbl: assert property (@(posedge clock) prop) \
   else $error("ddo reset check failed");

`endif

FILE: hw/rtl/ddo_pkg.sv
// Shared types, constants and tables of the odometry core.
package ddo_pkg;

   localparam int unsigned PosW    = 24;
   localparam int unsigned HeadW   = 16;
   localparam int unsigned DeltaW  = 17;
   localparam int unsigned TrackW  = 18;
   localparam int unsigned DivNumW = 48;
   localparam int unsigned DivDenW = 35;
   localparam int unsigned TrigW   = 32;

   localparam logic [30:0]        Rad2BamQ16 = 31'd683565276;
   localparam logic signed [31:0] KinvQ30    = 32'sd652032874;
   localparam logic [30:0]        RadiusMax  = 31'h7FFFFFFF;
   localparam logic [17:0]        TrackReset = 18'd25600;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_SET_POSE,
      DP_MUL_TURN,
      DP_DIV_TURN,
      DP_SAVE_TURN,
      DP_COR_OLD,
      DP_SAVE_OLD,
      DP_MUL_HT,
      DP_DIV_RAD,
      DP_SAVE_RAD,
      DP_COR_NEW,
      DP_SAVE_NEW,
      DP_MUL_X,
      DP_ACC_X,
      DP_MUL_Y,
      DP_ACC_Y,
      DP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      take;
   } dp_cmd_type;

   typedef struct packed {
      logic opcode;
      logic same;
      logic turn_zero;
      logic div_done;
      logic cordic_done;
      logic out_free;
   } dp_status_type;

   // arctangent of 2^-i, 2^32 per turn
   function automatic logic [31:0] atan_turn32(input logic [4:0] idx);
      logic [31:0] val;
      unique case (idx)
         5'd0:  val = 32'd536870912;
         5'd1:  val = 32'd316933406;
         5'd2:  val = 32'd167458907;
         5'd3:  val = 32'd85004756;
         5'd4:  val = 32'd42667331;
         5'd5:  val = 32'd21354465;
         5'd6:  val = 32'd10679838;
         5'd7:  val = 32'd5340245;
         5'd8:  val = 32'd2670163;
         5'd9:  val = 32'd1335087;
         5'd10: val = 32'd667544;
         5'd11: val = 32'd333772;
         5'd12: val = 32'd166886;
         5'd13: val = 32'd83443;
         5'd14: val = 32'd41722;
         5'd15: val = 32'd20861;
         5'd16: val = 32'd10430;
         5'd17: val = 32'd5215;
         5'd18: val = 32'd2608;
         5'd19: val = 32'd1304;
         5'd20: val = 32'd652;
         5'd21: val = 32'd326;
         5'd22: val = 32'd163;
         5'd23: val = 32'd81;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

FILE: hw/rtl/ddo_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module ddo_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ddo_pkg::DivNumW-1:0]   num,
   input  logic [ddo_pkg::DivDenW-1:0]   den,
   output logic                          done,
   output logic [ddo_pkg::DivNumW-1:0]   quot
);

   localparam int unsigned NW   = ddo_pkg::DivNumW;
   localparam int unsigned DW   = ddo_pkg::DivDenW;
   localparam int unsigned CntW = $clog2(NW + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0]   quo_ff, quo_in;
   logic [DW-1:0]   rem_ff, rem_in;
   logic [DW-1:0]   den_ff, den_in;
   logic [DW:0]     trial;
   logic            fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[NW-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(NW);
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = fits ? DW'(trial - {1'b0, den_ff}) : trial[DW-1:0];
         quo_in = {quo_ff[NW-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

FILE: hw/rtl/ddo_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle.
module ddo_cordic #(
   parameter int unsigned STEPS      = 16,
   parameter int unsigned ANGLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [ddo_pkg::HeadW-1:0]           angle,
   output logic                                done,
   output logic signed [ddo_pkg::TrigW-1:0]    cos_val,
   output logic signed [ddo_pkg::TrigW-1:0]    sin_val
);

   localparam int unsigned ZW        = ANGLE_BITS + 1;
   localparam int unsigned XW        = 34;
   localparam int unsigned CntW      = $clog2(STEPS);
   localparam int unsigned AtanShift = 32 - ANGLE_BITS;
   localparam logic signed [ZW-1:0] Quarter  = ZW'(2 ** (ANGLE_BITS - 2));
   localparam logic signed [ZW-1:0] HalfTurn = ZW'(2 ** (ANGLE_BITS - 1));
   localparam logic [32:0]          AtanRnd  = 33'(2 ** (31 - ANGLE_BITS));

   logic signed [39:0]               z_wide;
   logic signed [ZW-1:0]             z_start, z_fold;
   logic                             fold;
   logic [32:0]                      atan_sum;
   logic signed [ZW-1:0]             step;
   logic signed [XW-1:0]             xs, ys, x_nx, y_nx;
   logic signed [ZW-1:0]             z_nx;

   logic                             busy_ff, done_ff, neg_ff;
   logic [CntW-1:0]                  cnt_ff;
   logic signed [XW-1:0]             x_ff, y_ff;
   logic signed [ZW-1:0]             z_ff;
   logic signed [ddo_pkg::TrigW-1:0] cos_ff, sin_ff;

   always_comb begin
      z_wide  = $signed({{24{angle[15]}}, angle}) <<< 16;
      z_start = ZW'(z_wide >>> AtanShift);
      fold    = 1'b1;
      if (z_start > Quarter) begin
         z_fold = z_start - HalfTurn;
      end else if (z_start < -Quarter) begin
         z_fold = z_start + HalfTurn;
      end else begin
         z_fold = z_start;
         fold   = 1'b0;
      end
      atan_sum = {1'b0, ddo_pkg::atan_turn32(5'(cnt_ff))} + AtanRnd;
      step     = $signed(ZW'(atan_sum >> AtanShift));
      xs       = x_ff >>> cnt_ff;
      ys       = y_ff >>> cnt_ff;
      if (!z_ff[ZW-1]) begin
         x_nx = x_ff - ys;
         y_nx = y_ff + xs;
         z_nx = z_ff - step;
      end else begin
         x_nx = x_ff + ys;
         y_nx = y_ff - xs;
         z_nx = z_ff + step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CntW'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= XW'(ddo_pkg::KinvQ30);
         y_ff   <= '0;
         z_ff   <= z_fold;
         neg_ff <= fold;
      end else if (busy_ff) begin
         x_ff <= x_nx;
         y_ff <= y_nx;
         z_ff <= z_nx;
         if (cnt_ff == CntW'(STEPS - 1)) begin
            cos_ff <= ddo_pkg::TrigW'(neg_ff ? -x_nx : x_nx);
            sin_ff <= ddo_pkg::TrigW'(neg_ff ? -y_nx : y_nx);
         end
      end
   end

   assign done    = done_ff;
   assign cos_val = cos_ff;
   assign sin_val = sin_ff;

endmodule

FILE: hw/rtl/ddo_datapath.sv
// Pose registers, shared multiplier, divider and CORDIC of the odometry core.
module ddo_datapath #(
   parameter int unsigned CORDIC_STEPS = 16,
   parameter int unsigned ANGLE_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ddo_pkg::dp_cmd_type                 cmd,
   output ddo_pkg::dp_status_type              status,
   input  logic                                req_valid,
   input  logic                                req_opcode,
   input  logic signed [ddo_pkg::DeltaW-1:0]   req_left_delta,
   input  logic signed [ddo_pkg::DeltaW-1:0]   req_right_delta,
   input  logic signed [15:0]                  req_set_x,
   input  logic signed [15:0]                  req_set_y,
   input  logic signed [15:0]                  req_set_heading,
   input  logic                                csr_write_en,
   input  logic [ddo_pkg::TrackW-1:0]          csr_write_data,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic signed [ddo_pkg::PosW-1:0]     rsp_x_out,
   output logic signed [ddo_pkg::PosW-1:0]     rsp_y_out,
   output logic signed [ddo_pkg::HeadW-1:0]    rsp_heading_out,
   output logic signed [ddo_pkg::HeadW-1:0]    rsp_heading_delta
);

   localparam int unsigned PW = ddo_pkg::PosW;
   localparam int unsigned HW = ddo_pkg::HeadW;
   localparam int unsigned TW = ddo_pkg::TrigW;

   logic [ddo_pkg::TrackW-1:0]   track_ff, ht;
   logic signed [PW-1:0]         pos_x_ff, pos_y_ff;
   logic [HW-1:0]                heading_ff, old_head_ff;
   logic                         opcode_ff;
   logic signed [ddo_pkg::DeltaW-1:0] left_ff, right_ff;
   logic [15:0]                  set_x_ff, set_y_ff, set_head_ff;
   logic signed [66:0]           prod_ff, prod_in, rnd_sum;
   logic [HW-1:0]                dh_ff;
   logic signed [31:0]           rad_ff;
   logic signed [TW-1:0]         co_ff, so_ff;
   logic signed [TW:0]           dsin_ff, dcos_ff;
   logic                         rsp_valid_ff;
   logic signed [PW-1:0]         x_out_ff, y_out_ff;
   logic [HW-1:0]                head_out_ff, head_dlt_ff;

   logic signed [17:0]           diff, sum;
   logic [17:0]                  diff_mag, sum_mag;
   logic                         same, small_turn, is_mul;
   logic signed [32:0]           ma;
   logic signed [33:0]           mb;
   logic signed [39:0]           delta, pos_sel, pos_sum;
   logic signed [PW-1:0]         pos_sat;
   logic                         div_start, div_done;
   logic [ddo_pkg::DivNumW-1:0]  div_num, div_quot;
   logic [ddo_pkg::DivDenW-1:0]  div_den;
   logic                         cor_start, cor_done;
   logic [HW-1:0]                cor_angle;
   logic signed [TW-1:0]         cor_cos, cor_sin;
   logic [30:0]                  rad_mag;
   logic                         rad_neg;

   always_comb begin
      ht         = (track_ff == '0) ? ddo_pkg::TrackW'(1) : track_ff;
      diff       = 18'(right_ff) - 18'(left_ff);
      sum        = 18'(right_ff) + 18'(left_ff);
      diff_mag   = diff[17] ? 18'(-diff) : diff;
      sum_mag    = sum[17] ? 18'(-sum) : sum;
      same       = left_ff == right_ff;
      small_turn = !same && (dh_ff == '0);

      div_start = (cmd.op == ddo_pkg::DP_DIV_TURN) || (cmd.op == ddo_pkg::DP_DIV_RAD);
      if (cmd.op == ddo_pkg::DP_DIV_TURN) begin
         div_den = {ht, 17'b0};
         div_num = prod_ff[47:0] + {14'b0, ht, 16'b0};
      end else begin
         div_den = ddo_pkg::DivDenW'(diff_mag);
         div_num = prod_ff[47:0] + 48'(diff_mag >> 1);
      end

      cor_start = (cmd.op == ddo_pkg::DP_COR_OLD) || (cmd.op == ddo_pkg::DP_COR_NEW);
      cor_angle = (cmd.op == ddo_pkg::DP_COR_NEW) ? heading_ff + dh_ff : heading_ff;

      is_mul = 1'b1;
      unique case (cmd.op)
         ddo_pkg::DP_MUL_TURN: begin
            ma = $signed({15'b0, diff_mag});
            mb = $signed({3'b0, ddo_pkg::Rad2BamQ16});
         end
         ddo_pkg::DP_MUL_HT: begin
            ma = $signed({15'b0, ht});
            mb = $signed({16'b0, sum_mag});
         end
         ddo_pkg::DP_MUL_X: begin
            ma = same ? 33'(left_ff) : (small_turn ? 33'(sum) : 33'(rad_ff));
            mb = (same || small_turn) ? 34'(co_ff) : 34'(dsin_ff);
         end
         ddo_pkg::DP_MUL_Y: begin
            ma = same ? 33'(left_ff) : (small_turn ? 33'(sum) : 33'(rad_ff));
            mb = (same || small_turn) ? 34'(so_ff) : 34'(dcos_ff);
         end
         default: begin
            ma     = '0;
            mb     = '0;
            is_mul = 1'b0;
         end
      endcase
      prod_in = ma * mb;

      rnd_sum = prod_ff + (small_turn ? 67'sh40000000 : 67'sh20000000);
      delta   = small_turn ? 40'(rnd_sum >>> 31) : 40'(rnd_sum >>> 30);
      pos_sel = (cmd.op == ddo_pkg::DP_ACC_Y) ? 40'(pos_y_ff) : 40'(pos_x_ff);
      pos_sum = pos_sel + delta;
      if (pos_sum > 40'sd8388607) begin
         pos_sat = 24'sh7FFFFF;
      end else if (pos_sum < -40'sd8388608) begin
         pos_sat = 24'sh800000;
      end else begin
         pos_sat = PW'(pos_sum);
      end

      rad_mag = (|div_quot[47:31]) ? ddo_pkg::RadiusMax : div_quot[30:0];
      rad_neg = sum[17] != diff[17];
   end

   ddo_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   ddo_cordic #(
      .STEPS      (CORDIC_STEPS),
      .ANGLE_BITS (ANGLE_BITS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (cor_angle),
      .done    (cor_done),
      .cos_val (cor_cos),
      .sin_val (cor_sin)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         track_ff     <= ddo_pkg::TrackReset;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         heading_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            track_ff <= csr_write_data;
         end
         if (cmd.op == ddo_pkg::DP_FINISH) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (cmd.op)
            ddo_pkg::DP_SET_POSE: begin
               pos_x_ff   <= {set_x_ff, 8'b0};
               pos_y_ff   <= {set_y_ff, 8'b0};
               heading_ff <= set_head_ff;
            end
            ddo_pkg::DP_SAVE_NEW: heading_ff <= heading_ff + dh_ff;
            ddo_pkg::DP_ACC_X:    pos_x_ff   <= pos_sat;
            ddo_pkg::DP_ACC_Y:    pos_y_ff   <= pos_sat;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && cmd.take) begin
         opcode_ff   <= req_opcode;
         left_ff     <= req_left_delta;
         right_ff    <= req_right_delta;
         set_x_ff    <= req_set_x;
         set_y_ff    <= req_set_y;
         set_head_ff <= req_set_heading;
         old_head_ff <= heading_ff;
      end
      if (is_mul) begin
         prod_ff <= prod_in;
      end
      unique case (cmd.op)
         ddo_pkg::DP_SAVE_TURN: dh_ff <= diff[17] ? -div_quot[15:0] : div_quot[15:0];
         ddo_pkg::DP_SAVE_RAD:  rad_ff <= rad_neg ? -$signed({1'b0, rad_mag})
                                                  : $signed({1'b0, rad_mag});
         ddo_pkg::DP_SAVE_OLD: begin
            co_ff <= cor_cos;
            so_ff <= cor_sin;
         end
         ddo_pkg::DP_SAVE_NEW: begin
            dsin_ff <= 33'(cor_sin) - 33'(so_ff);
            dcos_ff <= 33'(co_ff) - 33'(cor_cos);
         end
         ddo_pkg::DP_FINISH: begin
            x_out_ff    <= pos_x_ff;
            y_out_ff    <= pos_y_ff;
            head_out_ff <= heading_ff;
            head_dlt_ff <= heading_ff - old_head_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      status.opcode      = opcode_ff;
      status.same        = same;
      status.turn_zero   = dh_ff == '0;
      status.div_done    = div_done;
      status.cordic_done = cor_done;
      status.out_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_x_out         = x_out_ff;
   assign rsp_y_out         = y_out_ff;
   assign rsp_heading_out   = head_out_ff;
   assign rsp_heading_delta = head_dlt_ff;

endmodule

FILE: hw/rtl/ddo_ctrl.sv
// Sequencer that steps the datapath through one word.
module ddo_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  ddo_pkg::dp_status_type status,
   output ddo_pkg::dp_cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_MUL_T,
      S_DIV_TURN,
      S_SAVE_T,
      S_COR_OLD,
      S_SAVE_O,
      S_MUL_R,
      S_DIV_RAD,
      S_SAVE_R,
      S_COR_NEW,
      S_SAVE_N,
      S_MUL_X,
      S_ACC_X,
      S_MUL_Y,
      S_ACC_Y,
      S_OUT
   } state_type;

   state_type           state_ff;
   ddo_pkg::dp_cmd_type cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cmd_ff.op   <= ddo_pkg::DP_NOP;
         cmd_ff.take <= 1'b0;
      end else begin
         cmd_ff.op   <= ddo_pkg::DP_NOP;
         cmd_ff.take <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && cmd_ff.take) begin
                  state_ff <= S_DISPATCH;
               end else begin
                  cmd_ff.take <= 1'b1;
               end
            end
            S_DISPATCH: begin
               priority if (status.opcode) begin
                  cmd_ff.op <= ddo_pkg::DP_SET_POSE;
                  state_ff  <= S_OUT;
               end else if (status.same) begin
                  cmd_ff.op <= ddo_pkg::DP_COR_OLD;
                  state_ff  <= S_COR_OLD;
               end else begin
                  cmd_ff.op <= ddo_pkg::DP_MUL_TURN;
                  state_ff  <= S_MUL_T;
               end
            end
            S_MUL_T: begin
               cmd_ff.op <= ddo_pkg::DP_DIV_TURN;
               state_ff  <= S_DIV_TURN;
            end
            S_DIV_TURN: begin
               if (status.div_done) begin
                  cmd_ff.op <= ddo_pkg::DP_SAVE_TURN;
                  state_ff  <= S_SAVE_T;
               end
            end
            S_SAVE_T: begin
               cmd_ff.op <= ddo_pkg::DP_COR_OLD;
               state_ff  <= S_COR_OLD;
            end
            S_COR_OLD: begin
               if (status.cordic_done) begin
                  cmd_ff.op <= ddo_pkg::DP_SAVE_OLD;
                  state_ff  <= S_SAVE_O;
               end
            end
            S_SAVE_O: begin
               if (!status.same && !status.turn_zero) begin
                  cmd_ff.op <= ddo_pkg::DP_MUL_HT;
                  state_ff  <= S_MUL_R;
               end else begin
                  cmd_ff.op <= ddo_pkg::DP_MUL_X;
                  state_ff  <= S_MUL_X;
               end
            end
            S_MUL_R: begin
               cmd_ff.op <= ddo_pkg::DP_DIV_RAD;
               state_ff  <= S_DIV_RAD;
            end
            S_DIV_RAD: begin
               if (status.div_done) begin
                  cmd_ff.op <= ddo_pkg::DP_SAVE_RAD;
                  state_ff  <= S_SAVE_R;
               end
            end
            S_SAVE_R: begin
               cmd_ff.op <= ddo_pkg::DP_COR_NEW;
               state_ff  <= S_COR_NEW;
            end
            S_COR_NEW: begin
               if (status.cordic_done) begin
                  cmd_ff.op <= ddo_pkg::DP_SAVE_NEW;
                  state_ff  <= S_SAVE_N;
               end
            end
            S_SAVE_N: begin
               cmd_ff.op <= ddo_pkg::DP_MUL_X;
               state_ff  <= S_MUL_X;
            end
            S_MUL_X: begin
               cmd_ff.op <= ddo_pkg::DP_ACC_X;
               state_ff  <= S_ACC_X;
            end
            S_ACC_X: begin
               cmd_ff.op <= ddo_pkg::DP_MUL_Y;
               state_ff  <= S_MUL_Y;
            end
            S_MUL_Y: begin
               cmd_ff.op <= ddo_pkg::DP_ACC_Y;
               state_ff  <= S_ACC_Y;
            end
            S_ACC_Y: begin
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (status.out_free) begin
                  cmd_ff.op   <= ddo_pkg::DP_FINISH;
                  cmd_ff.take <= 1'b1;
                  state_ff    <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign cmd = cmd_ff;

endmodule

FILE: hw/rtl/differential_drive_odometry_core.sv
// Top level of the differential drive odometry core.
// Usage:
//  - req_* carries one word per control tick: opcode 0 moves the pose by the
//    left/right wheel travel, opcode 1 loads x, y (whole mm) and heading.
//  - rsp_* returns one word per request: x, y (1/256 mm), heading and the
//    heading change caused by that request.
//  - csr_write_en/csr_write_data load half_track; write only while idle.
// Timing: one request at a time. A set-pose word uses neither the divider nor
//  the CORDIC, a straight move runs the CORDIC once, a turn below one heading
//  step runs the divider and the CORDIC once each, and an arc runs each twice.
//  req_ready rises as the result is loaded, so the next word can be taken at
//  the edge where rsp_valid rises. The arc time is set by the 48-step
//  restoring divider used twice, then by the CORDIC iterations.
// Reset clears the pose to zero, half_track to 25600 and drops rsp_valid and req_ready.
// If rsp_ready stays low, the finished word is held in the output register;
//  the next request is still accepted and processed, and its result waits
//  until the held word is taken.
module differential_drive_odometry_core #(
   parameter int unsigned CORDIC_STEPS = 16,
   parameter int unsigned ANGLE_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_opcode,
   input  logic signed [ddo_pkg::DeltaW-1:0]   req_left_delta,
   input  logic signed [ddo_pkg::DeltaW-1:0]   req_right_delta,
   input  logic signed [15:0]                  req_set_x,
   input  logic signed [15:0]                  req_set_y,
   input  logic signed [15:0]                  req_set_heading,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [ddo_pkg::PosW-1:0]     rsp_x_out,
   output logic signed [ddo_pkg::PosW-1:0]     rsp_y_out,
   output logic signed [ddo_pkg::HeadW-1:0]    rsp_heading_out,
   output logic signed [ddo_pkg::HeadW-1:0]    rsp_heading_delta,
   input  logic                                csr_write_en,
   input  logic [ddo_pkg::TrackW-1:0]          csr_write_data
);

   ddo_pkg::dp_cmd_type    cmd;
   ddo_pkg::dp_status_type status;

   ddo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd)
   );

   ddo_datapath #(
      .CORDIC_STEPS (CORDIC_STEPS),
      .ANGLE_BITS   (ANGLE_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_valid         (req_valid),
      .req_opcode        (req_opcode),
      .req_left_delta    (req_left_delta),
      .req_right_delta   (req_right_delta),
      .req_set_x         (req_set_x),
      .req_set_y         (req_set_y),
      .req_set_heading   (req_set_heading),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_x_out         (rsp_x_out),
      .rsp_y_out         (rsp_y_out),
      .rsp_heading_out   (rsp_heading_out),
      .rsp_heading_delta (rsp_heading_delta)
   );

   assign req_ready = cmd.take;

endmodule

FILE: hw/rtl/ddo_checker.sv
// Port-level checks of the odometry core and their bind.
`include "differential_drive_odometry_core_defines.svh"

module ddo_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [ddo_pkg::PosW-1:0]   rsp_x_out,
   input logic signed [ddo_pkg::PosW-1:0]   rsp_y_out
);

   `DDO_CHECK(a_busy_after_accept, req_valid && req_ready |=> !req_ready)
   `DDO_CHECK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_x_out) && $stable(rsp_y_out))
   `DDO_CHECK_RST(a_reset_clear, reset |=> !rsp_valid && !req_ready)

endmodule

bind differential_drive_odometry_core ddo_checker u_ddo_checker (.*);
